// ===== rtl/core/trimp_pkg.sv =====
// ----------------------------------------------------------------------------
// trimp_pkg: shared definitions of the tour reversal improver
// Sizes, fixed-point widths and item opcodes used by the core, the square
// root unit and the port checker.
// ----------------------------------------------------------------------------
package trimp_pkg;

  localparam int unsigned MaxCities = 16;
  localparam int unsigned CityW     = $clog2(MaxCities);
  localparam int unsigned CountW    = CityW + 1;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned SqW       = 2 * CoordW + 1;
  localparam int unsigned RootW     = CoordW + 1;
  localparam int unsigned LenW      = 24;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  localparam logic [1:0] OpCity = 2'd0;
  localparam logic [1:0] OpTour = 2'd1;
  localparam logic [1:0] OpTry  = 2'd2;

  localparam logic [CountW-1:0] MinUsed = CountW'(3);
  localparam logic [CountW-1:0] MaxUsed = CountW'(MaxCities);
  localparam logic [4:0]        CitiesReset = 5'(MaxCities);

endpackage

// ===== rtl/core/trimp_isqrt.sv =====
// ----------------------------------------------------------------------------
// trimp_isqrt: iterative floor square root
// Restoring bit-pair square root of a sum of two squares, one result bit per
// cycle; done pulses for one cycle when the root is valid.
// ----------------------------------------------------------------------------
module trimp_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [trimp_pkg::SqW-1:0]    value_i,
  output logic                         done_o,
  output logic [trimp_pkg::RootW-1:0]  root_o
);
  import trimp_pkg::*;

  localparam int unsigned AccW  = SqW + 1;
  localparam int unsigned Steps = (SqW + 1) / 2;
  localparam int unsigned CntW  = $clog2(Steps);

  logic [SqW-1:0]  v_q, v_d;
  logic [AccW-1:0] res_q, res_d, bit_q, bit_d, trial;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            active_q, active_d, done_q, done_d;

  assign trial = res_q + bit_q;

  always_comb begin
    v_d      = v_q;
    res_d    = res_q;
    bit_d    = bit_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = 1'b0;
    if (start_i) begin
      v_d      = value_i;
      res_d    = '0;
      bit_d    = AccW'(1) << (2 * (Steps - 1));
      cnt_d    = '0;
      active_d = 1'b1;
    end else if (active_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_d   = SqW'({1'b0, v_q} - trial);
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Steps - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];

endmodule

// ===== rtl/core/tour_reversal_improver_top.sv =====
// ----------------------------------------------------------------------------
// tour_reversal_improver_top: two-opt segment reversal test on a closed tour
// Holds city coordinates and one tour, measures the tour before and after a
// segment reversal and keeps the reversal when it shortens the tour.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start_i while busy_o is low. Opcode 0 writes the x/y of
//   city slot_i, opcode 1 writes city_i at tour position slot_i; both take
//   effect at the accepting edge and never raise busy_o. Opcode 3 is dropped.
//   Opcode 2 tries reversing the segment between first_pos_i and second_pos_i
//   and raises busy_o until its result has been shown.
//   The result shows on length_before_o, length_after_o and accepted_o for
//   exactly one cycle with done_o high; the receiver cannot stall it.
//   Each edge of a walk passes through four table reads, the difference, two
//   passes through the shared multiplier and 17 steps of the square root
//   unit. A try walks the tour once, walks the trial tour again when the
//   positions differ, and swaps the segment pair by pair if it is kept.
//   cities_in_use sits at APB address 0; write it only while busy_o is low.
//   Reset restores cities_in_use to 16 and idles the sequencer; the city and
//   tour tables hold garbage until written.
// ----------------------------------------------------------------------------
module tour_reversal_improver_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      opcode_i,
  input  logic [trimp_pkg::CityW-1:0]     slot_i,
  input  logic [trimp_pkg::CoordW-1:0]    coord_x_i,
  input  logic [trimp_pkg::CoordW-1:0]    coord_y_i,
  input  logic [trimp_pkg::CityW-1:0]     city_i,
  input  logic [trimp_pkg::CityW-1:0]     first_pos_i,
  input  logic [trimp_pkg::CityW-1:0]     second_pos_i,
  output logic                            done_o,
  output logic [trimp_pkg::LenW-1:0]      length_before_o,
  output logic [trimp_pkg::LenW-1:0]      length_after_o,
  output logic                            accepted_o
);
  import trimp_pkg::*;

  typedef enum logic [13:0] {
    StIdle = 14'b00000000000001,
    StTa   = 14'b00000000000010,
    StTb   = 14'b00000000000100,
    StCa   = 14'b00000000001000,
    StCb   = 14'b00000000010000,
    StDiff = 14'b00000000100000,
    StMx   = 14'b00000001000000,
    StMy   = 14'b00000010000000,
    StSqrt = 14'b00000100000000,
    StSra  = 14'b00001000000000,
    StSrb  = 14'b00010000000000,
    StSw1  = 14'b00100000000000,
    StSw2  = 14'b01000000000000,
    StOut  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration register
  logic [4:0] cities_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, cities_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cities_q <= CitiesReset;
    end else if (cfg_wr) begin
      cities_q <= pwdata[4:0];
    end
  end

  // Tables: one write port, one registered read port each
  logic [CoordW-1:0] cx_mem [MaxCities];
  logic [CoordW-1:0] cy_mem [MaxCities];
  logic [CityW-1:0]  tour_mem [MaxCities];
  logic [CoordW-1:0] cx_rd_q, cy_rd_q;
  logic [CityW-1:0]  tour_rd_q;
  logic [CityW-1:0]  city_raddr, tour_raddr, tour_waddr, tour_wdata;
  logic              tour_we, accept;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (accept && opcode_i == OpCity) begin
      cx_mem[slot_i] <= coord_x_i;
      cy_mem[slot_i] <= coord_y_i;
    end
    cx_rd_q <= cx_mem[city_raddr];
    cy_rd_q <= cy_mem[city_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tour_we) begin
      tour_mem[tour_waddr] <= tour_wdata;
    end
    tour_rd_q <= tour_mem[tour_raddr];
  end

  // Sequencer state
  logic [CountW-1:0] n_q, n_d, n_clamp;
  logic [CityW-1:0]  p1_q, p1_d, p2_q, p2_d, pa, pb;
  logic [CityW-1:0]  i_q, i_d, i_next, lo_q, lo_d, hi_q, hi_d;
  logic [CityW-1:0]  ca_q, ca_d, cb_q, cb_d, tmp_q, tmp_d;
  logic [CoordW-1:0] xa_q, xa_d, ya_q, ya_d, dx_q, dx_d, dy_q, dy_d;
  logic [SqW-1:0]    acc_q, acc_d, sq_value;
  logic [LenW-1:0]   sum_q, sum_d, sum_acc, before_q, before_d, after_q, after_d;
  logic              walk_q, walk_d, keep_q, keep_d, last_edge;
  logic [2*CoordW-1:0] prod;
  logic [LenW:0]     sum_wide;
  logic              sq_start, sq_done;
  logic [RootW-1:0]  sq_root;

  // Map a tour position into the trial tour of the second walk
  function automatic logic [CityW-1:0] map_pos(input logic [CityW-1:0] j,
                                               input logic             rev,
                                               input logic [CityW-1:0] a,
                                               input logic [CityW-1:0] b);
    logic [CityW:0] mirror;
    mirror = {1'b0, a} + {1'b0, b} - {1'b0, j};
    if (rev && j >= a && j <= b) begin
      return mirror[CityW-1:0];
    end
    return j;
  endfunction

  always_comb begin
    n_clamp = (cities_q < MinUsed) ? MinUsed :
              (cities_q > MaxUsed) ? MaxUsed : cities_q;
    pa = ({1'b0, first_pos_i} >= n_clamp) ? CityW'(n_clamp - CountW'(1)) : first_pos_i;
    pb = ({1'b0, second_pos_i} >= n_clamp) ? CityW'(n_clamp - CountW'(1)) : second_pos_i;
  end

  assign last_edge = ({1'b0, i_q} + CountW'(1)) == n_q;
  assign i_next    = last_edge ? '0 : i_q + CityW'(1);

  // Shared multiplier: dx squared, then dy squared
  assign prod     = ((state_q == StMx) ? dx_q : dy_q) * ((state_q == StMx) ? dx_q : dy_q);
  assign sq_value = acc_q + SqW'(prod);
  assign sq_start = (state_q == StMy);

  // Saturating length accumulate
  assign sum_wide = {1'b0, sum_q} + (LenW + 1)'(sq_root);
  assign sum_acc  = (sum_wide > {1'b0, LenMax}) ? LenMax : sum_wide[LenW-1:0];

  trimp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_value),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    i_d      = i_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ca_d     = ca_q;
    cb_d     = cb_q;
    tmp_d    = tmp_q;
    xa_d     = xa_q;
    ya_d     = ya_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    acc_d    = acc_q;
    sum_d    = sum_q;
    before_d = before_q;
    after_d  = after_q;
    walk_d   = walk_q;
    keep_d   = keep_q;
    city_raddr = ca_q;
    tour_raddr = map_pos(i_q, walk_q, p1_q, p2_q);
    tour_we    = accept && (opcode_i == OpTour);
    tour_waddr = slot_i;
    tour_wdata = city_i;

    unique case (state_q)
      StIdle: begin
        if (accept && opcode_i == OpTry) begin
          n_d     = n_clamp;
          p1_d    = (pa > pb) ? pb : pa;
          p2_d    = (pa > pb) ? pa : pb;
          i_d     = '0;
          sum_d   = '0;
          walk_d  = 1'b0;
          keep_d  = 1'b0;
          state_d = StTa;
        end
      end
      StTa: begin
        state_d = StTb;
      end
      StTb: begin
        tour_raddr = map_pos(i_next, walk_q, p1_q, p2_q);
        ca_d       = tour_rd_q;
        state_d    = StCa;
      end
      StCa: begin
        cb_d       = tour_rd_q;
        city_raddr = ca_q;
        state_d    = StCb;
      end
      StCb: begin
        xa_d       = cx_rd_q;
        ya_d       = cy_rd_q;
        city_raddr = cb_q;
        state_d    = StDiff;
      end
      StDiff: begin
        dx_d    = (xa_q > cx_rd_q) ? xa_q - cx_rd_q : cx_rd_q - xa_q;
        dy_d    = (ya_q > cy_rd_q) ? ya_q - cy_rd_q : cy_rd_q - ya_q;
        state_d = StMx;
      end
      StMx: begin
        acc_d   = SqW'(prod);
        state_d = StMy;
      end
      StMy: begin
        state_d = StSqrt;
      end
      StSqrt: begin
        if (sq_done) begin
          if (!last_edge) begin
            sum_d   = sum_acc;
            i_d     = i_next;
            state_d = StTa;
          end else if (!walk_q) begin
            before_d = sum_acc;
            if (p1_q == p2_q) begin
              after_d = sum_acc;
              state_d = StOut;
            end else begin
              walk_d  = 1'b1;
              sum_d   = '0;
              i_d     = '0;
              state_d = StTa;
            end
          end else begin
            after_d = sum_acc;
            if (sum_acc < before_q) begin
              keep_d  = 1'b1;
              lo_d    = p1_q;
              hi_d    = p2_q;
              state_d = StSra;
            end else begin
              state_d = StOut;
            end
          end
        end
      end
      StSra: begin
        tour_raddr = lo_q;
        state_d    = StSrb;
      end
      StSrb: begin
        tour_raddr = hi_q;
        tmp_d      = tour_rd_q;
        state_d    = StSw1;
      end
      StSw1: begin
        tour_we    = 1'b1;
        tour_waddr = lo_q;
        tour_wdata = tour_rd_q;
        state_d    = StSw2;
      end
      StSw2: begin
        tour_we    = 1'b1;
        tour_waddr = hi_q;
        tour_wdata = tmp_q;
        lo_d       = lo_q + CityW'(1);
        hi_d       = hi_q - CityW'(1);
        // Advance while the two ends have not met
        state_d    = ({1'b0, lo_q} + CountW'(2) < {1'b0, hi_q}) ? StSra : StOut;
      end
      StOut: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      walk_q  <= 1'b0;
      keep_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      walk_q  <= walk_d;
      keep_q  <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    tmp_q    <= tmp_d;
    xa_q     <= xa_d;
    ya_q     <= ya_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    acc_q    <= acc_d;
    sum_q    <= sum_d;
    before_q <= before_d;
    after_q  <= after_d;
  end

  assign busy_o          = (state_q != StIdle);
  assign done_o          = (state_q == StOut);
  assign length_before_o = before_q;
  assign length_after_o  = after_q;
  assign accepted_o      = keep_q;

endmodule

// ===== rtl/core/trimp_checker.sv =====
// ----------------------------------------------------------------------------
// trimp_checker: port-level checks of the tour reversal improver
// Watches the item handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module trimp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [1:0]                   opcode_i,
  input logic                         done_o,
  input logic [trimp_pkg::LenW-1:0]   length_before_o,
  input logic [trimp_pkg::LenW-1:0]   length_after_o,
  input logic                         accepted_o
);
  import trimp_pkg::*;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result shown while idle");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_try_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OpTry) |=> busy_o)
    else $error("try item did not raise busy");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i != OpTry) |=> !busy_o)
    else $error("write item raised busy");

  a_keep_shorter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |-> (length_after_o < length_before_o))
    else $error("kept a reversal that is not shorter");

endmodule

bind tour_reversal_improver_top trimp_checker u_trimp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .opcode_i        (opcode_i),
  .done_o          (done_o),
  .length_before_o (length_before_o),
  .length_after_o  (length_after_o),
  .accepted_o      (accepted_o)
);
